// ===== src/rgt_pkg.sv =====
// ----------------------------------------------------------------------------
// rgt_pkg
// Shared types, constants and helper functions of the 2D grid ray walker.
// ----------------------------------------------------------------------------
package rgt_pkg;

  localparam int GRID_RES   = 16;
  localparam int GRID_LOG2  = $clog2(GRID_RES);
  localparam int IDX_W      = GRID_LOG2;
  localparam int BIT_W      = (IDX_W > 1) ? $clog2(IDX_W) : 1;
  localparam int OUT_IDX_W  = 4;
  localparam int MAX_STEPS  = 2 * GRID_RES - 2;
  localparam int CNT_W      = $clog2(2 * GRID_RES);

  localparam int COORD_W    = 32;
  localparam int SPAN_W     = 31;
  localparam int NUM_W      = 40;
  localparam int DEN_W      = 40;
  localparam int CHUNK_W    = 10;
  localparam int N_CHUNK    = DEN_W / CHUNK_W;
  localparam int ACC_W      = NUM_W + DEN_W + 2;
  localparam int QDEPTH     = 2;

  localparam int CFG_IDX_W  = 2;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_LEFT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_TOP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_HEIGHT = 2'd3;

  localparam logic signed [COORD_W-1:0] BOX_LEFT_RST   = 32'sd16384;
  localparam logic signed [COORD_W-1:0] BOX_TOP_RST    = 32'sd16384;
  localparam logic [SPAN_W-1:0]         BOX_WIDTH_RST  = 31'd26214;
  localparam logic [SPAN_W-1:0]         BOX_HEIGHT_RST = 31'd26214;

  typedef logic signed [NUM_W-1:0] num_t;
  typedef logic [DEN_W-1:0]        den_t;

  typedef struct packed {
    num_t num;
    den_t den;
  } frac_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_z;
    logic signed [COORD_W-1:0] end_x;
    logic signed [COORD_W-1:0] end_z;
  } in_t;

  typedef struct packed {
    logic                 hit;
    logic [OUT_IDX_W-1:0] cell_col;
    logic [OUT_IDX_W-1:0] cell_row;
    logic                 last;
  } out_t;

  // One ray in grid units, relative to the box corner.
  typedef struct packed {
    num_t u0;
    num_t v0;
    num_t du;
    num_t dv;
    logic miss;
  } job_t;

  // Time at which p + d*t reaches target, as a fraction with positive
  // denominator. d must be nonzero.
  function automatic frac_t time_to(num_t target, num_t p, num_t d);
    frac_t f;
    if (d > 0) begin
      f.num = target - p;
      f.den = den_t'(d);
    end else begin
      f.num = p - target;
      f.den = den_t'(-d);
    end
    return f;
  endfunction

  // Position of boundary k on an axis whose cells are s wide.
  function automatic num_t span_mul(logic [IDX_W:0] k, logic [SPAN_W-1:0] s);
    logic [IDX_W+SPAN_W:0] prod;
    prod = k * s;
    return num_t'(prod);
  endfunction

endpackage

// ===== src/rgt_cmp.sv =====
// ----------------------------------------------------------------------------
// rgt_cmp
// Multi-cycle exact compare of two fractions an/ad and bn/bd by cross
// multiplication, one 10-bit slice of each denominator per cycle.
// ----------------------------------------------------------------------------
module rgt_cmp (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  rgt_pkg::num_t an_i,
  input  rgt_pkg::den_t ad_i,
  input  rgt_pkg::num_t bn_i,
  input  rgt_pkg::den_t bd_i,
  output logic          done_o,
  output logic          lt_o,
  output logic          eq_o
);
  import rgt_pkg::*;

  localparam int CCNT_W = $clog2(N_CHUNK + 1);

  num_t                      an_q, bn_q;
  den_t                      ad_q, bd_q;
  logic signed [ACC_W-1:0]   acc_q, acc_d;
  logic [CCNT_W-1:0]         cnt_q;
  logic                      done_q;
  logic signed [NUM_W+CHUNK_W:0] p1, p2;

  // Most significant slice first, so the accumulator only shifts left.
  assign p1 = an_q * $signed({1'b0, bd_q[DEN_W-1 -: CHUNK_W]});
  assign p2 = bn_q * $signed({1'b0, ad_q[DEN_W-1 -: CHUNK_W]});
  assign acc_d = (acc_q <<< CHUNK_W) + ACC_W'(p1) - ACC_W'(p2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q <= CCNT_W'(N_CHUNK);
      end else if (cnt_q != '0) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CCNT_W'(1)) begin
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      an_q  <= an_i;
      bn_q  <= bn_i;
      ad_q  <= ad_i;
      bd_q  <= bd_i;
      acc_q <= '0;
    end else if (cnt_q != '0) begin
      acc_q <= acc_d;
      ad_q  <= ad_q << CHUNK_W;
      bd_q  <= bd_q << CHUNK_W;
    end
  end

  assign done_o = done_q;
  assign lt_o   = acc_q[ACC_W-1];
  assign eq_o   = (acc_q == '0);

endmodule

// ===== src/rgt_front.sv =====
// ----------------------------------------------------------------------------
// rgt_front
// Takes rays, moves them into grid units relative to the box corner, flags
// rays that miss on an axis with no motion, and queues them for the walker.
// ----------------------------------------------------------------------------
module rgt_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  output logic                           busy_o,
  input  rgt_pkg::in_t                   item_i,
  input  logic signed [rgt_pkg::COORD_W-1:0] box_left_i,
  input  logic signed [rgt_pkg::COORD_W-1:0] box_top_i,
  input  logic [rgt_pkg::SPAN_W-1:0]     box_width_i,
  input  logic [rgt_pkg::SPAN_W-1:0]     box_height_i,
  output logic                           job_valid_o,
  output rgt_pkg::job_t                  job_o,
  input  logic                           job_pop_i
);
  import rgt_pkg::*;

  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  job_t              q_mem [QDEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              push;
  job_t              job_new;
  num_t              umax, vmax;

  function automatic num_t sx(logic signed [COORD_W-1:0] a);
    return num_t'(a);
  endfunction

  assign umax = num_t'(box_width_i) <<< GRID_LOG2;
  assign vmax = num_t'(box_height_i) <<< GRID_LOG2;

  always_comb begin
    job_new.u0 = (sx(item_i.origin_x) - sx(box_left_i)) <<< GRID_LOG2;
    job_new.v0 = (sx(item_i.origin_z) - sx(box_top_i)) <<< GRID_LOG2;
    job_new.du = (sx(item_i.end_x) - sx(item_i.origin_x)) <<< GRID_LOG2;
    job_new.dv = (sx(item_i.end_z) - sx(item_i.origin_z)) <<< GRID_LOG2;
    // An axis without motion misses unless the origin sits inside its slab.
    job_new.miss = ((job_new.du == '0) && ((job_new.u0 < 0) || (job_new.u0 > umax))) ||
                   ((job_new.dv == '0) && ((job_new.v0 < 0) || (job_new.v0 > vmax)));
  end

  assign busy_o      = (cnt_q == QCNT_W'(QDEPTH));
  assign push        = start_i && !busy_o;
  assign job_valid_o = (cnt_q != '0);
  assign job_o       = q_mem[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= wr_q + 1'b1;
      end
      if (job_pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      unique case ({push, job_pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_q] <= job_new;
    end
  end

endmodule

// ===== src/rgt_back.sv =====
// ----------------------------------------------------------------------------
// rgt_back
// Clips a queued ray against the box, finds the entry cell by binary search
// and walks the grid, emitting one result per visited cell, or a single result for a miss.
// ----------------------------------------------------------------------------
module rgt_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       job_valid_i,
  input  rgt_pkg::job_t              job_i,
  output logic                       job_pop_o,
  input  logic [rgt_pkg::SPAN_W-1:0] box_width_i,
  input  logic [rgt_pkg::SPAN_W-1:0] box_height_i,
  output logic                       result_valid_o,
  output rgt_pkg::out_t              result_o
);
  import rgt_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_MISS   = 4'd1;
  localparam logic [3:0] ST_V      = 4'd2;
  localparam logic [3:0] ST_VN_W   = 4'd3;
  localparam logic [3:0] ST_VF_W   = 4'd4;
  localparam logic [3:0] ST_CHK    = 4'd5;
  localparam logic [3:0] ST_CHK_W  = 4'd6;
  localparam logic [3:0] ST_ENT    = 4'd7;
  localparam logic [3:0] ST_ENT_W  = 4'd8;
  localparam logic [3:0] ST_WALK   = 4'd9;
  localparam logic [3:0] ST_WALK_W = 4'd10;

  logic [3:0]       state_q, state_d;
  num_t             u0_q, u0_d, v0_q, v0_d, du_q, du_d, dv_q, dv_d;
  frac_t            ten_q, ten_d, tex_q, tex_d;
  logic             have_q, have_d;
  logic [IDX_W-1:0] c_q, c_d, r_q, r_d;
  logic             axis_q, axis_d;
  logic [BIT_W-1:0] bit_q, bit_d;
  logic [CNT_W-1:0] n_q, n_d;
  logic             res_valid_q, res_valid_d;
  out_t             res_q, res_d;

  logic  cmp_start, cmp_done, cmp_lt, cmp_eq, cmp_gt;
  num_t  cmp_an, cmp_bn;
  den_t  cmp_ad, cmp_bd;

  num_t  umax, vmax;
  logic  du_nz, dv_nz, du_pos, dv_pos;
  frac_t v_near, v_far, tx, tz, t_bnd;
  logic [IDX_W-1:0] cur, trial;
  num_t  ent_p, ent_d, ent_b;
  logic  ent_dpos, ent_ok, past;
  logic  do_emit, step_x, step_z, last;

  rgt_cmp u_cmp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmp_start),
    .an_i    (cmp_an),
    .ad_i    (cmp_ad),
    .bn_i    (cmp_bn),
    .bd_i    (cmp_bd),
    .done_o  (cmp_done),
    .lt_o    (cmp_lt),
    .eq_o    (cmp_eq)
  );

  assign cmp_gt = !cmp_lt && !cmp_eq;

  assign umax   = num_t'(box_width_i) <<< GRID_LOG2;
  assign vmax   = num_t'(box_height_i) <<< GRID_LOG2;
  assign du_nz  = (du_q != '0);
  assign dv_nz  = (dv_q != '0);
  assign du_pos = du_nz && !du_q[NUM_W-1];
  assign dv_pos = dv_nz && !dv_q[NUM_W-1];

  assign v_near = time_to(dv_pos ? num_t'(0) : vmax, v0_q, dv_q);
  assign v_far  = time_to(dv_pos ? vmax : num_t'(0), v0_q, dv_q);

  // Next boundary crossings from the current cell.
  assign tx = time_to(span_mul(du_pos ? {1'b0, c_q} + 1'b1 : {1'b0, c_q}, box_width_i),
                      u0_q, du_q);
  assign tz = time_to(span_mul(dv_pos ? {1'b0, r_q} + 1'b1 : {1'b0, r_q}, box_height_i),
                      v0_q, dv_q);

  // Entry search: trial index sets one more bit of the count of boundaries
  // that lie at or before the entry point.
  assign cur      = axis_q ? r_q : c_q;
  assign trial    = cur | (IDX_W'(1) << bit_q);
  assign ent_ok   = ({1'b0, trial} <= (IDX_W + 1)'(GRID_RES - 1));
  assign ent_p    = axis_q ? v0_q : u0_q;
  assign ent_d    = axis_q ? dv_q : du_q;
  assign ent_dpos = !ent_d[NUM_W-1];
  assign ent_b    = span_mul({1'b0, trial}, axis_q ? box_height_i : box_width_i);
  assign t_bnd    = time_to(ent_b, ent_p, ent_d);
  assign past     = ent_ok && (((ent_d == '0) || ent_dpos) ? !cmp_lt : (cmp_lt || cmp_eq));

  always_comb begin
    state_d     = state_q;
    u0_d        = u0_q;
    v0_d        = v0_q;
    du_d        = du_q;
    dv_d        = dv_q;
    ten_d       = ten_q;
    tex_d       = tex_q;
    have_d      = have_q;
    c_d         = c_q;
    r_d         = r_q;
    axis_d      = axis_q;
    bit_d       = bit_q;
    n_d         = n_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    job_pop_o   = 1'b0;
    cmp_start   = 1'b0;
    cmp_an      = ten_q.num;
    cmp_ad      = ten_q.den;
    cmp_bn      = tex_q.num;
    cmp_bd      = tex_q.den;
    do_emit     = 1'b0;
    step_x      = 1'b0;
    step_z      = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          u0_d      = job_i.u0;
          v0_d      = job_i.v0;
          du_d      = job_i.du;
          dv_d      = job_i.dv;
          if (job_i.du != '0) begin
            have_d = 1'b1;
            ten_d  = time_to(job_i.du > 0 ? num_t'(0) : umax, job_i.u0, job_i.du);
            tex_d  = time_to(job_i.du > 0 ? umax : num_t'(0), job_i.u0, job_i.du);
          end else begin
            have_d    = 1'b0;
            ten_d.num = '0;
            ten_d.den = den_t'(1);
            tex_d.num = '0;
            tex_d.den = den_t'(1);
          end
          state_d = job_i.miss ? ST_MISS : ST_V;
        end
      end
      ST_MISS: begin
        res_valid_d    = 1'b1;
        res_d.hit      = 1'b0;
        res_d.cell_col = '0;
        res_d.cell_row = '0;
        res_d.last     = 1'b1;
        state_d        = ST_IDLE;
      end
      ST_V: begin
        if (!dv_nz) begin
          state_d = ST_CHK;
        end else if (!have_q) begin
          ten_d   = v_near;
          tex_d   = v_far;
          have_d  = 1'b1;
          state_d = ST_CHK;
        end else begin
          cmp_start = 1'b1;
          cmp_an    = v_near.num;
          cmp_ad    = v_near.den;
          cmp_bn    = ten_q.num;
          cmp_bd    = ten_q.den;
          state_d   = ST_VN_W;
        end
      end
      ST_VN_W: begin
        if (cmp_done) begin
          if (cmp_gt) begin
            ten_d = v_near;
          end
          cmp_start = 1'b1;
          cmp_an    = v_far.num;
          cmp_ad    = v_far.den;
          cmp_bn    = tex_q.num;
          cmp_bd    = tex_q.den;
          state_d   = ST_VF_W;
        end
      end
      ST_VF_W: begin
        if (cmp_done) begin
          if (cmp_lt) begin
            tex_d = v_far;
          end
          state_d = ST_CHK;
        end
      end
      ST_CHK: begin
        axis_d = 1'b0;
        bit_d  = BIT_W'(IDX_W - 1);
        c_d    = '0;
        r_d    = '0;
        if (have_q) begin
          cmp_start = 1'b1;
          state_d   = ST_CHK_W;
        end else begin
          state_d = ST_ENT;
        end
      end
      ST_CHK_W: begin
        if (cmp_done) begin
          state_d = cmp_gt ? ST_MISS : ST_ENT;
        end
      end
      ST_ENT: begin
        cmp_start = 1'b1;
        if (ent_d == '0) begin
          cmp_an = ent_p;
          cmp_ad = den_t'(1);
          cmp_bn = ent_b;
          cmp_bd = den_t'(1);
        end else begin
          cmp_an = ten_q.num;
          cmp_ad = ten_q.den;
          cmp_bn = t_bnd.num;
          cmp_bd = t_bnd.den;
        end
        state_d = ST_ENT_W;
      end
      ST_ENT_W: begin
        if (cmp_done) begin
          if (past) begin
            if (axis_q) begin
              r_d = trial;
            end else begin
              c_d = trial;
            end
          end
          if (bit_q == '0) begin
            if (!axis_q) begin
              axis_d  = 1'b1;
              bit_d   = BIT_W'(IDX_W - 1);
              state_d = ST_ENT;
            end else begin
              n_d     = '0;
              state_d = ST_WALK;
            end
          end else begin
            bit_d   = bit_q - 1'b1;
            state_d = ST_ENT;
          end
        end
      end
      ST_WALK: begin
        if (du_nz && dv_nz) begin
          cmp_start = 1'b1;
          cmp_an    = tx.num;
          cmp_ad    = tx.den;
          cmp_bn    = tz.num;
          cmp_bd    = tz.den;
          state_d   = ST_WALK_W;
        end else begin
          do_emit = 1'b1;
          step_x  = du_nz;
          step_z  = dv_nz;
        end
      end
      ST_WALK_W: begin
        // On a tie the row steps.
        if (cmp_done) begin
          do_emit = 1'b1;
          step_x  = cmp_lt;
          step_z  = !cmp_lt;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    last = (!step_x && !step_z) ||
           (step_x && (du_pos ? (c_q == IDX_W'(GRID_RES - 1)) : (c_q == '0))) ||
           (step_z && (dv_pos ? (r_q == IDX_W'(GRID_RES - 1)) : (r_q == '0))) ||
           (n_q >= CNT_W'(MAX_STEPS));

    if (do_emit) begin
      res_valid_d    = 1'b1;
      res_d.hit      = 1'b1;
      res_d.cell_col = OUT_IDX_W'(c_q);
      res_d.cell_row = OUT_IDX_W'(r_q);
      res_d.last     = last;
      if (last) begin
        state_d = ST_IDLE;
      end else begin
        if (step_x) begin
          c_d = du_pos ? c_q + 1'b1 : c_q - 1'b1;
        end
        if (step_z) begin
          r_d = dv_pos ? r_q + 1'b1 : r_q - 1'b1;
        end
        n_d     = n_q + 1'b1;
        state_d = ST_WALK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    u0_q   <= u0_d;
    v0_q   <= v0_d;
    du_q   <= du_d;
    dv_q   <= dv_d;
    ten_q  <= ten_d;
    tex_q  <= tex_d;
    have_q <= have_d;
    c_q    <= c_d;
    r_q    <= r_d;
    axis_q <= axis_d;
    bit_q  <= bit_d;
    n_q    <= n_d;
    res_q  <= res_d;
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

// ===== src/ray_grid_traversal_2d.sv =====
// ----------------------------------------------------------------------------
// ray_grid_traversal_2d
// Clips a line against a box split into a 16 x 16 grid and lists the cells
// it crosses in traversal order.
// ----------------------------------------------------------------------------
// Usage:
//   A ray (origin and second point, Q16.16) is taken when start_i is high and
//   busy_o is low. A two-entry queue sits between the input stage and the
//   walker, so up to two rays may wait while one is walked.
//   Each result appears on result_o for one cycle with result_valid_o high;
//   the receiver cannot stall, every strobe is a transfer. The final result
//   of a ray has last set; a miss is a single result with hit low.
//   All exact comparisons go through one shared cross-multiply unit.
//   Clipping takes up to 3 compares, the entry cell 8 (a binary search per
//   axis), and each cell of a ray that moves on both axes one compare; a ray
//   lists up to 31 cells. Rays along an axis walk one cell per cycle.
//   The box registers are written through cfg_we_i/cfg_idx_i/cfg_wdata_i;
//   the user must write them only while the block is idle, as the block
//   itself does not enforce it. Reset empties the queue, stops any walk
//   and loads the default box (0.25, 0.25, 0.4 x 0.4).
// ----------------------------------------------------------------------------
module ray_grid_traversal_2d (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  rgt_pkg::in_t                      item_i,
  output logic                              result_valid_o,
  output rgt_pkg::out_t                     result_o,
  input  logic                              cfg_we_i,
  input  logic [rgt_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [rgt_pkg::COORD_W-1:0]       cfg_wdata_i
);
  import rgt_pkg::*;

  logic signed [COORD_W-1:0] box_left_q, box_top_q;
  logic [SPAN_W-1:0]         box_width_q, box_height_q;
  logic                      job_valid, job_pop;
  job_t                      job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      box_left_q   <= BOX_LEFT_RST;
      box_top_q    <= BOX_TOP_RST;
      box_width_q  <= BOX_WIDTH_RST;
      box_height_q <= BOX_HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_BOX_LEFT:   box_left_q   <= cfg_wdata_i;
        REG_BOX_TOP:    box_top_q    <= cfg_wdata_i;
        REG_BOX_WIDTH:  box_width_q  <= cfg_wdata_i[SPAN_W-1:0];
        REG_BOX_HEIGHT: box_height_q <= cfg_wdata_i[SPAN_W-1:0];
        default:        box_left_q   <= box_left_q;
      endcase
    end
  end

  rgt_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .item_i       (item_i),
    .box_left_i   (box_left_q),
    .box_top_i    (box_top_q),
    .box_width_i  (box_width_q),
    .box_height_i (box_height_q),
    .job_valid_o  (job_valid),
    .job_o        (job),
    .job_pop_i    (job_pop)
  );

  rgt_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (job_valid),
    .job_i          (job),
    .job_pop_o      (job_pop),
    .box_width_i    (box_width_q),
    .box_height_i   (box_height_q),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

// ===== src/rgt_checker.sv =====
// ----------------------------------------------------------------------------
// rgt_checker
// Port-level checks of the result stream of the grid ray walker.
// ----------------------------------------------------------------------------
module rgt_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start_i,
  input logic          busy_o,
  input logic          result_valid_o,
  input rgt_pkg::out_t result_o
);
  import rgt_pkg::*;

  // A miss carries zero indices and closes its ray.
  a_miss_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.hit) |->
      (result_o.last && (result_o.cell_col == '0) && (result_o.cell_row == '0)))
    else $error("miss result with stray fields");

  // Only visited cells can be followed by more results of the same ray.
  a_nonlast_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.last) |-> result_o.hit)
    else $error("non-final result is not a hit");

  // After the final result the walker passes through idle to load a ray, so no result follows in the next cycle.
  a_gap_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.last) |=> !result_valid_o)
    else $error("result right after the final one");

  // Right after reset the queue is empty and no result is out.
  a_busy_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> (!busy_o && !result_valid_o))
    else $error("busy or result right after reset");

endmodule

bind ray_grid_traversal_2d rgt_checker u_rgt_checker (.*);

// ===== tb/ray_grid_traversal_2d_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_grid_traversal_2d_checker
// Watches the ray, result and register ports of the grid walker. It works
// out the cell list of every accepted ray exactly and compares each result
// transfer against the oldest expected cell.
// ----------------------------------------------------------------------------
module ray_grid_traversal_2d_checker
  import rgt_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 busy_o,
  input  in_t                  item_i,
  input  logic                 result_valid_o,
  input  out_t                 result_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [COORD_W-1:0]   cfg_wdata_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  typedef struct {
    longint n;
    longint d;
  } ratio_t;

  longint left_q, top_q, width_q, height_q;
  out_t   cells_q[$];

  // Sign of a - b, exact by cross multiplication.
  function automatic int ratio_cmp(ratio_t a, ratio_t b);
    logic signed [127:0] lhs, rhs, an, ad, bn, bd;
    an = a.n; ad = a.d; bn = b.n; bd = b.d;
    lhs = an * bd;
    rhs = bn * ad;
    if (lhs < rhs) return -1;
    if (lhs > rhs) return 1;
    return 0;
  endfunction

  function automatic ratio_t reach_time(longint target, longint p, longint d);
    ratio_t r;
    if (d > 0) begin
      r.n = target - p; r.d = d;
    end else begin
      r.n = p - target; r.d = -d;
    end
    return r;
  endfunction

  function automatic int entry_cell(longint p, longint d, longint span, ratio_t t_in);
    int     c;
    int     k;
    longint b;
    logic   past;
    c = 0;
    for (int j = 1; j < GRID_RES; j++) begin
      b = j * span;
      if (d == 0) begin
        past = p >= b;
      end else begin
        k = ratio_cmp(t_in, reach_time(b, p, d));
        past = (d > 0) ? (k >= 0) : (k <= 0);
      end
      if (past) c++;
    end
    return c;
  endfunction

  task automatic predict_cells(in_t it);
    longint u0, v0, du, dv, umax, vmax;
    ratio_t t_in, t_out, tn, tf, tx, tz;
    logic   have, miss, sx, sz, fin;
    int     c, r, nc, nr, n;
    out_t   res;
    u0 = (longint'(it.origin_x) - left_q) * GRID_RES;
    v0 = (longint'(it.origin_z) - top_q) * GRID_RES;
    du = (longint'(it.end_x) - longint'(it.origin_x)) * GRID_RES;
    dv = (longint'(it.end_z) - longint'(it.origin_z)) * GRID_RES;
    umax = width_q * GRID_RES;
    vmax = height_q * GRID_RES;
    t_in = '{0, 1};
    t_out = '{0, 1};
    have = 0;
    miss = 0;
    if (du != 0) begin
      t_in = reach_time(du > 0 ? 0 : umax, u0, du);
      t_out = reach_time(du > 0 ? umax : 0, u0, du);
      have = 1;
    end else if (u0 < 0 || u0 > umax) begin
      miss = 1;
    end
    if (dv != 0) begin
      tn = reach_time(dv > 0 ? 0 : vmax, v0, dv);
      tf = reach_time(dv > 0 ? vmax : 0, v0, dv);
      if (!have || ratio_cmp(tn, t_in) > 0) t_in = tn;
      if (!have || ratio_cmp(tf, t_out) < 0) t_out = tf;
      have = 1;
    end else if (v0 < 0 || v0 > vmax) begin
      miss = 1;
    end
    if (!miss && have && ratio_cmp(t_in, t_out) > 0) miss = 1;
    if (miss) begin
      cells_q.push_back('{hit: 1'b0, cell_col: '0, cell_row: '0, last: 1'b1});
      return;
    end
    c = entry_cell(u0, du, width_q, t_in);
    r = entry_cell(v0, dv, height_q, t_in);
    n = 0;
    forever begin
      sx = 0; sz = 0;
      nc = c; nr = r;
      if (du != 0 && dv != 0) begin
        tx = reach_time((du > 0 ? c + 1 : c) * width_q, u0, du);
        tz = reach_time((dv > 0 ? r + 1 : r) * height_q, v0, dv);
        // On a tie the row steps.
        if (ratio_cmp(tx, tz) < 0) sx = 1; else sz = 1;
      end else if (du != 0) begin
        sx = 1;
      end else if (dv != 0) begin
        sz = 1;
      end
      if (sx) nc += (du > 0) ? 1 : -1;
      if (sz) nr += (dv > 0) ? 1 : -1;
      fin = (!sx && !sz) || nc < 0 || nc >= GRID_RES || nr < 0 || nr >= GRID_RES ||
            n >= MAX_STEPS;
      res.hit = 1'b1;
      res.cell_col = OUT_IDX_W'(c);
      res.cell_row = OUT_IDX_W'(r);
      res.last = fin;
      cells_q.push_back(res);
      n++;
      if (fin) break;
      c = nc;
      r = nr;
    end
  endtask

  assign pending_o = cells_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      left_q <= longint'(BOX_LEFT_RST);
      top_q <= longint'(BOX_TOP_RST);
      width_q <= longint'(BOX_WIDTH_RST);
      height_q <= longint'(BOX_HEIGHT_RST);
      cells_q.delete();
      fail_count_o <= 0;
    end else begin
      if (result_valid_o) begin
        if (cells_q.size() == 0) begin
          $error("result transfer with no cell expected: %p", result_o);
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = cells_q.pop_front();
          if (result_o !== want) begin
            fail_count_o <= fail_count_o + 1;
            if (result_o.hit !== want.hit)
              $error("hit: expected %0d, got %0d", want.hit, result_o.hit);
            if (result_o.cell_col !== want.cell_col)
              $error("cell_col: expected %0d, got %0d", want.cell_col, result_o.cell_col);
            if (result_o.cell_row !== want.cell_row)
              $error("cell_row: expected %0d, got %0d", want.cell_row, result_o.cell_row);
            if (result_o.last !== want.last)
              $error("last: expected %0d, got %0d", want.last, result_o.last);
          end
        end
      end
      if (start_i && !busy_o) predict_cells(item_i);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_BOX_LEFT:   left_q <= longint'($signed(cfg_wdata_i));
          REG_BOX_TOP:    top_q <= longint'($signed(cfg_wdata_i));
          REG_BOX_WIDTH:  width_q <= longint'(cfg_wdata_i[SPAN_W-1:0]);
          REG_BOX_HEIGHT: height_q <= longint'(cfg_wdata_i[SPAN_W-1:0]);
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== tb/ray_grid_traversal_2d_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_grid_traversal_2d_test
// Drives rays into the grid walker under several box settings, with random
// gaps between rays, and takes the verdict from the checker beside it.
// ----------------------------------------------------------------------------
module ray_grid_traversal_2d_test;
  import rgt_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 start_i = 1'b0;
  logic                 busy_o;
  in_t                  item_i = '0;
  logic                 result_valid_o;
  out_t                 result_o;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = REG_BOX_LEFT;
  logic [COORD_W-1:0]   cfg_wdata_i = '0;
  int                   fail_count;
  int                   pending;
  int                   cycles = 0;
  int                   gap_pct = 0;

  longint box_x = longint'(BOX_LEFT_RST), box_z = longint'(BOX_TOP_RST);
  longint box_w = longint'(BOX_WIDTH_RST), box_h = longint'(BOX_HEIGHT_RST);

  always #4 clk_i = ~clk_i;

  ray_grid_traversal_2d dut (.*);

  ray_grid_traversal_2d_checker checker_i (
    .clk_i, .rst_ni, .start_i, .busy_o, .item_i, .result_valid_o, .result_o,
    .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_ray(longint ox, longint oz, longint ex, longint ez);
    logic ready;
    start_i <= 1'b1;
    item_i <= '{COORD_W'(ox), COORD_W'(oz), COORD_W'(ex), COORD_W'(ez)};
    do begin
      @(negedge clk_i);
      ready = !busy_o;
      @(posedge clk_i);
    end while (!ready);
    // Each following cycle idles with the current gap probability.
    if ($urandom_range(99) < gap_pct) begin
      start_i <= 1'b0;
      do begin
        @(posedge clk_i);
      end while ($urandom_range(99) < gap_pct);
    end
  endtask

  // Waits until the walker has drained, then lets it settle.
  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic set_box(longint x, longint z, longint w, longint h);
    drain();
    box_x = x; box_z = z; box_w = w; box_h = h;
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_BOX_LEFT;   cfg_wdata_i <= COORD_W'(x); @(posedge clk_i);
    cfg_idx_i <= REG_BOX_TOP;    cfg_wdata_i <= COORD_W'(z); @(posedge clk_i);
    cfg_idx_i <= REG_BOX_WIDTH;  cfg_wdata_i <= COORD_W'(w); @(posedge clk_i);
    cfg_idx_i <= REG_BOX_HEIGHT; cfg_wdata_i <= COORD_W'(h); @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // A coordinate near the box on one axis, often right on a cell boundary.
  function automatic longint near_box(longint lo, longint span);
    if ($urandom_range(3) == 0)
      return lo + ($urandom_range(GRID_RES) * span) / GRID_RES;
    return lo - span / 2 + longint'($urandom_range(0, 32'(2 * span)));
  endfunction

  task automatic random_ray();
    longint ox, oz, ex, ez;
    int     kind;
    kind = $urandom_range(99);
    ox = near_box(box_x, box_w);
    oz = near_box(box_z, box_h);
    ex = near_box(box_x, box_w);
    ez = near_box(box_z, box_h);
    if (kind < 15) begin
      ox = $urandom; oz = $urandom; ex = $urandom; ez = $urandom;
    end else if (kind < 25) begin
      ez = oz;
    end else if (kind < 35) begin
      ex = ox;
    end else if (kind < 40) begin
      ex = ox; ez = oz;
    end else if (kind < 48) begin
      // Equal steps on both axes, in cell units, make the boundary crossings tie when the origin lies on a cell corner.
      ex = ox + box_w; ez = oz + box_h;
    end
    send_ray(ox, oz, ex, ez);
  endtask

  initial begin
    longint lo, hi, mid;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    lo = -64'sd2147483648; hi = 64'sd2147483647; mid = 32768;
    send_ray(mid, mid, mid + 100, mid + 37);
    send_ray(mid, mid, mid - 100, mid - 37);
    send_ray(0, mid, 65536, mid);
    send_ray(mid, 0, mid, 65536);
    send_ray(mid, mid, mid, mid);
    send_ray(0, 0, 0, 0);
    send_ray(0, 0, 65536, 65536);
    send_ray(65536, 65536, 0, 0);
    send_ray(16384, 0, 16384, 65536);
    send_ray(0, 16384, 65536, 16384);
    send_ray(0, 58982, 58982, 0);
    send_ray(0, 0, 10, 0);
    send_ray(lo, lo, hi, hi);
    send_ray(hi, hi, lo, lo);
    send_ray(lo, hi, hi, lo);
    send_ray(hi, lo, lo, lo);
    send_ray(hi, hi, hi, hi);
    send_ray(lo, lo, lo, lo);
    send_ray(-1, -1, 0, 0);
    send_ray(mid, mid, mid + 1, mid);

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_box(16384, 16384, 26214, 26214);
        1: set_box(0, 0, 16, 32);
        2: set_box(-64'sd2147483648, -64'sd2147483648, 64'sd2147483647, 64'sd2147483647);
        3: set_box(64'sd2147483647, -1000, 1, 1);
        4: set_box(-655360, 327680, 16 * 65536, 16 * 4096);
        default: set_box(-64'sd2147483648, 64'sd2147483647, 64'sd2147483647, 160);
      endcase
      for (int i = 0; i < 58; i++) begin
        gap_pct = (i < 19) ? 38 : (i < 38) ? 83 : 0;
        if (i == 29) drain();
        random_ray();
      end
    end

    drain();
    repeat (300) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
